### rtl/cossim_pkg.sv
`default_nettype none
package cossim_pkg;

  localparam int SQ_W    = 44;
  localparam int CROSS_W = 45;
  localparam int SIM_W   = 24;

  localparam logic signed [15:0] SCALE_RESET = 16'sd4096;

  // sums of one finished vector pair
  typedef struct packed {
    logic [SQ_W-1:0]           xx;
    logic [SQ_W-1:0]           yy;
    logic signed [CROSS_W-1:0] xy;
  } sums_t;

endpackage
`default_nettype wire

### rtl/cossim_front.sv
`default_nettype none
module cossim_front
  import cossim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic signed [15:0] first_elem,
  input  wire logic signed [15:0] second_elem,
  input  wire logic               last_elem,
  output logic                    q_push,
  output sums_t                   q_data
);

  logic [SQ_W-1:0]           sum_first_sq;
  logic [SQ_W-1:0]           sum_second_sq;
  logic signed [CROSS_W-1:0] sum_cross;

  logic signed [31:0]        pxx, pyy, pxy;
  logic [SQ_W:0]             sxx, syy;
  logic [CROSS_W:0]          sxy;
  sums_t                     upd;

  // element products and saturating sums
  always_comb begin
    pxx = first_elem * first_elem;
    pyy = second_elem * second_elem;
    pxy = first_elem * second_elem;
    sxx = {1'b0, sum_first_sq} + {14'b0, pxx[30:0]};
    syy = {1'b0, sum_second_sq} + {14'b0, pyy[30:0]};
    sxy = {sum_cross[CROSS_W-1], sum_cross} + {{14{pxy[31]}}, pxy};
    upd.xx = sxx[SQ_W] ? {SQ_W{1'b1}} : sxx[SQ_W-1:0];
    upd.yy = syy[SQ_W] ? {SQ_W{1'b1}} : syy[SQ_W-1:0];
    if (sxy[CROSS_W] != sxy[CROSS_W-1]) begin
      upd.xy = sxy[CROSS_W] ? {1'b1, {(CROSS_W-1){1'b0}}} : {1'b0, {(CROSS_W-1){1'b1}}};
    end else begin
      upd.xy = sxy[CROSS_W-1:0];
    end
  end

  assign q_push = accept && last_elem;
  assign q_data = upd;

  // accumulate, clear after the last word of a pair
  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      sum_first_sq  <= '0;
      sum_second_sq <= '0;
      sum_cross     <= '0;
    end else if (accept) begin
      sum_first_sq  <= upd.xx;
      sum_second_sq <= upd.yy;
      sum_cross     <= upd.xy;
    end
  end

endmodule
`default_nettype wire

### rtl/cossim_queue.sv
`default_nettype none
module cossim_queue
  import cossim_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire sums_t wdata,
  input  wire logic  pop,
  output logic       full,
  output logic       valid,
  output sums_t      rdata
);

  sums_t       mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = mem[rd_ptr];

  // two-entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/cossim_back.sv
`default_nettype none
module cossim_back
  import cossim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic signed [15:0] scale,
  input  wire logic               q_valid,
  input  wire sums_t              q_data,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output logic signed [SIM_W-1:0] similarity,
  output logic                    zero_norm_error
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULN = 7'b0000010,
    S_MULQ = 7'b0000100,
    S_MULD = 7'b0001000,
    S_ADD  = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t          state;
  logic [127:0]    mul_a, mul_acc;
  logic [63:0]     mul_b;
  logic [126:0]    nn;
  logic [137:0]    p, t, e, cand;
  logic [23:0]     r;
  logic [4:0]      k;
  logic            neg, err;
  logic [SQ_W-1:0] xx, yy;
  logic            out_valid;

  logic [15:0]        abs_scale;
  logic [CROSS_W-1:0] abs_xy;
  logic [23:0]        mag;
  logic               out_free;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // magnitudes of the operands and the clamped result
  always_comb begin
    abs_scale = scale[15] ? 16'(-scale) : scale;
    abs_xy    = q_data.xy[CROSS_W-1] ? CROSS_W'(-q_data.xy) : q_data.xy;
    if (neg) begin
      mag = (r > 24'h800000) ? 24'h800000 : r;
    end else begin
      mag = (r > 24'h7fffff) ? 24'h7fffff : r;
    end
  end

  // sequencer: shift-add products, then one result bit per pass through the add and compare states
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= ((state == S_FIN) && out_free) || (out_valid && !pop);
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            xx      <= q_data.xx;
            yy      <= q_data.yy;
            neg     <= scale[15] != q_data.xy[CROSS_W-1];
            err     <= (q_data.xx == '0) || (q_data.yy == '0);
            r       <= '0;
            mul_a   <= {108'b0, abs_scale, 4'b0};
            mul_b   <= {19'b0, abs_xy};
            mul_acc <= '0;
            state   <= ((q_data.xx == '0) || (q_data.yy == '0)) ? S_FIN : S_MULN;
          end
        end
        S_MULN, S_MULQ, S_MULD: begin
          if (mul_b == '0) begin
            mul_acc <= '0;
            if (state == S_MULN) begin
              mul_a <= mul_acc;
              mul_b <= mul_acc[63:0];
              state <= S_MULQ;
            end else if (state == S_MULQ) begin
              nn    <= mul_acc[126:0];
              mul_a <= {84'b0, xx};
              mul_b <= {20'b0, yy};
              state <= S_MULD;
            end else begin
              p     <= '0;
              t     <= '0;
              e     <= {4'b0, mul_acc[87:0], 46'b0};
              k     <= 5'd23;
              state <= S_ADD;
            end
          end else begin
            if (mul_b[0]) mul_acc <= mul_acc + mul_a;
            mul_a <= {mul_a[126:0], 1'b0};
            mul_b <= {1'b0, mul_b[63:1]};
          end
        end
        S_ADD: begin
          cand  <= p + t + e;
          state <= S_CMP;
        end
        S_CMP: begin
          if (cand <= {11'b0, nn}) begin
            p    <= cand;
            r[k] <= 1'b1;
            t    <= (t + {e[136:0], 1'b0}) >> 1;
          end else begin
            t    <= t >> 1;
          end
          e     <= e >> 2;
          k     <= k - 5'd1;
          state <= (k == 5'd0) ? S_FIN : S_ADD;
        end
        S_FIN: begin
          if (out_free) begin
            similarity      <= err ? '0 : (neg ? 24'(24'd0 - mag) : mag);
            zero_norm_error <= err;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/cosine_similarity_forward_core.sv
`default_nettype none
// Streaming cosine similarity. Element pairs are pushed one word per cycle while
// full is low and summed as x*x, y*y and x*y with saturation; the word with
// last_elem set closes the pair and yields one result, scale*xy/sqrt(xx*yy) in
// signed Q8.16, or 0 with zero_norm_error when a norm is zero. Accumulation runs
// at one word per clock unless the queue is full. The result is worked out by a
// shared shift-add multiplier (three products in turn) followed by a 24-bit root
// search that settles one bit per add and compare step; a two-entry queue of sums
// lets the next vectors stream in meanwhile, so short pairs can fill it and stall
// push.
module cosine_similarity_forward_core
  import cossim_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic signed [15:0] cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] first_elem,
  input  wire logic signed [15:0] second_elem,
  input  wire logic               last_elem,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [SIM_W-1:0] similarity,
  output logic                    zero_norm_error
);

  logic signed [15:0] scale_factor;
  logic               q_push, q_pop, q_full, q_valid;
  sums_t              q_wdata, q_rdata;

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= SCALE_RESET;
    end else if (cfg_we) begin
      scale_factor <= cfg_data;
    end
  end

  assign full = q_full;

  cossim_front u_front (
    .clk(clk), .rst(rst), .accept(push && !q_full),
    .first_elem(first_elem), .second_elem(second_elem), .last_elem(last_elem),
    .q_push(q_push), .q_data(q_wdata)
  );

  cossim_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .full(q_full), .valid(q_valid), .rdata(q_rdata)
  );

  cossim_back u_back (
    .clk(clk), .rst(rst), .scale(scale_factor), .q_valid(q_valid), .q_data(q_rdata),
    .q_pop(q_pop), .pop(pop && !empty), .empty(empty), .similarity(similarity),
    .zero_norm_error(zero_norm_error)
  );

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("sums queue overflow");
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && zero_norm_error) |-> (similarity == '0))
    else $error("nonzero result with zero norm");
`endif

endmodule
`default_nettype wire

### sim/cosine_similarity_forward_core_test.sv
`default_nettype none
module cosine_similarity_forward_core_test;
  import cossim_pkg::*;

  localparam longint unsigned SUM_SQ_MAX = (64'd1 << SQ_W - 1 + 1) - 1;
  localparam longint SUM_XY_MAX = longint'((64'd1 << (CROSS_W - 1)) - 1);
  localparam longint SUM_XY_MIN = -SUM_XY_MAX - 1;
  localparam int DRAIN_CYCLES = 300;

  // one queued word: either an element pair or a scale register write
  typedef struct {
    bit                 is_scale;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               lst;
  } word_t;

  typedef struct {
    logic signed [SIM_W-1:0] sim;
    logic                    err;
  } cos_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic signed [15:0] cfg_data;
  logic push;
  logic full;
  logic signed [15:0] first_elem;
  logic signed [15:0] second_elem;
  logic last_elem;
  logic empty;
  logic pop;
  logic signed [SIM_W-1:0] similarity;
  logic zero_norm_error;

  word_t pending_words[$];
  cos_result_t expected_cos[$];

  // predictor state
  longint unsigned acc_xx;
  longint unsigned acc_yy;
  longint acc_xy;
  logic signed [15:0] scale_reg;

  int errors;
  int words_in;
  int results_out;
  int zero_norm_seen;
  int scale_writes;
  int phase1_at;
  int phase2_at;
  int drain_cnt;

  cosine_similarity_forward_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .first_elem(first_elem),
    .second_elem(second_elem),
    .last_elem(last_elem),
    .empty(empty),
    .pop(pop),
    .similarity(similarity),
    .zero_norm_error(zero_norm_error)
  );

  // largest r <= cap with r*r*xx*yy <= n*n
  function automatic longint unsigned cos_root(input longint unsigned n,
                                               input longint unsigned xx,
                                               input longint unsigned yy,
                                               input longint unsigned cap);
    logic [191:0] d;
    logic [191:0] rhs;
    logic [191:0] lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    d = 192'(xx) * 192'(yy);
    rhs = 192'(n) * 192'(n);
    lo = 0;
    hi = cap;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      lhs = 192'(mid * mid) * d;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // accumulate one element pair; on last word queue the expected result
  function automatic void accumulate_pair(input word_t w);
    longint xs;
    longint ys;
    longint c;
    longint unsigned p;
    longint unsigned as_mag;
    longint unsigned ax;
    longint unsigned r;
    bit neg;
    cos_result_t res;
    xs = longint'(w.x);
    ys = longint'(w.y);
    p = longint'(xs * xs);
    acc_xx = (p > SUM_SQ_MAX - acc_xx) ? SUM_SQ_MAX : acc_xx + p;
    p = longint'(ys * ys);
    acc_yy = (p > SUM_SQ_MAX - acc_yy) ? SUM_SQ_MAX : acc_yy + p;
    c = acc_xy + xs * ys;
    if (c > SUM_XY_MAX) c = SUM_XY_MAX;
    if (c < SUM_XY_MIN) c = SUM_XY_MIN;
    acc_xy = c;
    if (w.lst) begin
      res.sim = '0;
      res.err = 1'b0;
      if (acc_xx == 0 || acc_yy == 0) begin
        res.err = 1'b1;
      end else begin
        neg = (scale_reg < 0) != (acc_xy < 0);
        as_mag = (scale_reg < 0) ? -longint'(scale_reg) : longint'(scale_reg);
        ax = (acc_xy < 0) ? -acc_xy : acc_xy;
        r = cos_root(as_mag * 16 * ax, acc_xx, acc_yy, neg ? 64'd8388608 : 64'd8388607);
        res.sim = neg ? SIM_W'(-r) : SIM_W'(r);
      end
      expected_cos.push_back(res);
      acc_xx = 0;
      acc_yy = 0;
      acc_xy = 0;
    end
  endfunction

  function automatic void add_pair(input int x, input int y, input bit lst);
    word_t w;
    w.is_scale = 0;
    w.x = 16'(x);
    w.y = 16'(y);
    w.lst = lst;
    pending_words.push_back(w);
  endfunction

  function automatic void add_scale(input int v);
    word_t w;
    w.is_scale = 1;
    w.x = 16'(v);
    w.y = 0;
    w.lst = 0;
    pending_words.push_back(w);
  endfunction

  function automatic int sender_idle_pct();
    if (words_in < phase1_at) return 33;
    if (words_in < phase2_at) return 71;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (words_in < phase1_at) return 71;
    if (words_in < phase2_at) return 33;
    return 0;
  endfunction

  // clock and reset
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
  end

  // driver: push element pairs, write the scale once the block has drained
  always @(posedge clk) begin
    logic nxt_push;
    logic nxt_we;
    word_t w;
    if (rst) begin
      push <= 0;
      cfg_we <= 0;
      drain_cnt <= 0;
    end else begin
      nxt_push = push;
      nxt_we = 0;
      if (push && !full) begin
        accumulate_pair(pending_words.pop_front());
        words_in++;
        nxt_push = 0;
      end
      if (!nxt_push && pending_words.size() > 0) begin
        w = pending_words[0];
        if (w.is_scale) begin
          if (expected_cos.size() == 0 && drain_cnt >= DRAIN_CYCLES) begin
            nxt_we = 1;
            cfg_data <= w.x;
            scale_reg = w.x;
            scale_writes++;
            void'(pending_words.pop_front());
            drain_cnt <= 0;
          end else if (expected_cos.size() == 0) begin
            drain_cnt <= drain_cnt + 1;
          end else begin
            drain_cnt <= 0;
          end
        end else if ($urandom_range(99) >= sender_idle_pct()) begin
          nxt_push = 1;
          first_elem <= w.x;
          second_elem <= w.y;
          last_elem <= w.lst;
        end
      end
      push <= nxt_push;
      cfg_we <= nxt_we;
    end
  end

  // monitor: pop results and compare with the oldest expectation
  always @(posedge clk) begin
    cos_result_t e;
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        results_out++;
        if (expected_cos.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, actual sim=%0d err=%0b",
                   $time, similarity, zero_norm_error);
        end else begin
          e = expected_cos.pop_front();
          if (e.err) zero_norm_seen++;
          if (similarity !== e.sim) begin
            errors++;
            $display("%0t: similarity mismatch: expected %0d, actual %0d",
                     $time, e.sim, similarity);
          end
          if (zero_norm_error !== e.err) begin
            errors++;
            $display("%0t: zero_norm_error mismatch: expected %0b, actual %0b",
                     $time, e.err, zero_norm_error);
          end
        end
      end
      pop <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // stimulus and end of run
  initial begin
    int scale_opts[5];
    int n_rand;
    int len;
    int mode;
    int x;
    int y;
    int since_scale;
    errors = 0;
    words_in = 0;
    results_out = 0;
    zero_norm_seen = 0;
    scale_writes = 0;
    acc_xx = 0;
    acc_yy = 0;
    acc_xy = 0;
    scale_reg = SCALE_RESET;
    cfg_we = 0;
    cfg_data = 0;
    push = 0;
    pop = 0;
    first_elem = 0;
    second_elem = 0;
    last_elem = 0;
    drain_cnt = 0;

    // directed: extremes, zero norms, multi-word pairs, scale extremes
    add_pair(32767, 32767, 1);
    add_pair(-32768, -32768, 1);
    add_pair(-32768, 32767, 1);
    add_pair(0, 5, 1);
    add_pair(5, 0, 1);
    add_pair(0, 0, 1);
    add_pair(100, 200, 0);
    add_pair(300, -400, 1);
    add_scale(-32768);
    add_pair(-32768, -32768, 1);
    add_pair(1000, -1000, 1);
    add_pair(1, 1, 1);
    add_scale(32767);
    add_pair(32767, 32767, 1);
    add_pair(32767, -32768, 1);
    add_pair(3, 4, 0);
    add_pair(4, 3, 1);
    add_scale(0);
    add_pair(123, 456, 1);
    add_pair(0, 9, 1);

    // random vector pairs, scale changed now and then
    scale_opts = '{-32768, 32767, 0, 4096, 0};
    n_rand = 0;
    since_scale = 0;
    phase1_at = 20 + 550;
    phase2_at = 20 + 1100;
    while (n_rand < 1625) begin
      if (since_scale > 350) begin
        scale_opts[4] = $urandom_range(65535);
        add_scale(scale_opts[$urandom_range(4)]);
        since_scale = 0;
      end
      len = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      mode = $urandom_range(9);
      for (int i = 0; i < len; i++) begin
        x = $signed(16'($urandom));
        y = $signed(16'($urandom));
        case (mode)
          5: begin
            x = $signed(16'($urandom_range(600))) - 300;
            y = $signed(16'($urandom_range(600))) - 300;
          end
          6: x = 0;
          7: y = x;
          8: y = (x == -32768) ? 32767 : -x;
          9: begin
            x = $urandom_range(1) ? 32767 : -32768;
            y = $urandom_range(1) ? 32767 : -32768;
          end
          default: ;
        endcase
        add_pair(x, y, i == len - 1);
      end
      n_rand += len;
      since_scale += len;
    end

    while (pending_words.size() > 0 || expected_cos.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d element words, %0d results (%0d zero norm), %0d scale writes",
             words_in, results_out, zero_norm_seen, scale_writes);
    $display("idle mixes on both sides, extreme scales and elements, short and long vectors");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
rtl/cossim_pkg.sv
rtl/cossim_front.sv
rtl/cossim_queue.sv
rtl/cossim_back.sv
rtl/cosine_similarity_forward_core.sv
sim/cosine_similarity_forward_core_test.sv
